@@ hdl/rhd_pkg.sv @@
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared types and constants for the random hemisphere direction unit.
// ----------------------------------------------------------------------------
package rhd_pkg;

  localparam int unsigned FieldW = 18;
  localparam int unsigned TriesW = 8;

  localparam logic [31:0] GenOneReset = 32'd1151752134;
  localparam logic [31:0] GenTwoReset = 32'd2070363486;
  localparam logic [31:0] MulOne      = 32'd1701532575;
  localparam logic [31:0] AddOne      = 32'd571550083;
  localparam logic [31:0] MulTwo      = 32'd3145804233;
  localparam logic [31:0] AddTwo      = 32'd4178903934;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GEN,
    ST_SQ,
    ST_SUM,
    ST_NUM,
    ST_DIV,
    ST_DOT,
    ST_SUMDOT,
    ST_OUT
  } rhd_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic start;     // latch reference, clear try count
    logic gen;       // step generators, shift in one uniform
    logic sq;        // form the four squares and the cross products
    logic sum;       // add squares and square pairs, bump try count
    logic num;       // form the three numerators
    logic div_step;  // load the divider or take one quotient bit
    logic div_next;  // store quotient, move to next component
    logic dot;       // form dot product terms
    logic sumdot;    // add terms and flip
  } rhd_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic draw_ok;   // d2 is nonzero and at most one
    logic div_last;  // all quotient bits of this component are done
    logic comp_last; // third component being divided
  } rhd_stat_t;

endpackage

@@ hdl/rhd_ctrl.sv @@
// ----------------------------------------------------------------------------
// rhd_ctrl
// Sequencer for draw, rejection, division and flip.
// ----------------------------------------------------------------------------
module rhd_ctrl
  import rhd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output rhd_cmd_t  cmd,
  input  rhd_stat_t stat
);

  rhd_state_t state_r, state_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_GEN;
        end
      end
      ST_GEN: begin
        cmd.gen = 1'b1;
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_NUM;
      end
      ST_NUM: begin
        if (stat.draw_ok) begin
          cmd.num   = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_GEN;
        end
      end
      ST_DIV: begin
        if (!stat.div_last) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.div_next = 1'b1;
          if (stat.comp_last) begin
            state_nxt = ST_DOT;
          end
        end
      end
      ST_DOT: begin
        cmd.dot   = 1'b1;
        state_nxt = ST_SUMDOT;
      end
      ST_SUMDOT: begin
        cmd.sumdot = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ hdl/rhd_dp.sv @@
// ----------------------------------------------------------------------------
// rhd_dp
// Generators, squares, restoring divider and flip datapath.
// ----------------------------------------------------------------------------
module rhd_dp
  import rhd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  rhd_cmd_t                 cmd,
  output rhd_stat_t                stat,
  input  logic signed [FieldW-1:0] in_ref_x,
  input  logic signed [FieldW-1:0] in_ref_y,
  input  logic signed [FieldW-1:0] in_ref_z,
  output logic signed [FieldW-1:0] out_dir_x,
  output logic signed [FieldW-1:0] out_dir_y,
  output logic signed [FieldW-1:0] out_dir_z,
  output logic [TriesW-1:0]        out_tries
);

  logic [31:0] g1_r, g2_r, g1_n, g2_n, w;
  logic signed [15:0] u_r [4];
  logic [31:0] sq_r [4];
  logic [32:0] d2_r;
  logic signed [33:0] p_r [6];
  logic signed [33:0] num_r [3];
  logic [TriesW-1:0] tries_r;
  logic signed [FieldW-1:0] ref_r [3];
  logic signed [FieldW-1:0] dir_r [3];
  // Divider: magnitude * 2^16 + d2/2 over d2, a 50-bit dividend taken one
  // quotient bit per cycle.
  logic [49:0] dvd_r;
  logic [33:0] rem_r;
  logic [5:0]  bit_r;
  logic [1:0]  comp_r;
  logic        neg_r;
  logic signed [36:0] dt_r [3];
  logic [33:0] mag;
  logic [34:0] rem_sh, rem_sub;
  logic [49:0] q;
  logic [16:0] qs;
  logic signed [38:0] dot;

  assign g1_n = g1_r * MulOne + AddOne;
  assign g2_n = g2_r * MulTwo + AddTwo;
  assign w    = {g1_n[15:0], 16'h0} ^ g2_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_r <= GenOneReset;
      g2_r <= GenTwoReset;
    end else if (cmd.gen) begin
      g1_r <= g1_n;
      g2_r <= g2_n;
    end
  end

  assign stat.draw_ok   = (d2_r != 33'd0) && (d2_r <= 33'h4000_0000);
  assign stat.div_last  = (bit_r == 6'd51);
  assign stat.comp_last = (comp_r == 2'd2);

  assign mag     = num_r[comp_r][33] ? 34'(-num_r[comp_r]) : 34'(num_r[comp_r]);
  assign rem_sh  = {rem_r, dvd_r[49]};
  assign rem_sub = rem_sh - {2'b0, d2_r};
  assign q       = dvd_r;
  assign qs      = (q > 50'd65536) ? 17'd65536 : q[16:0];

  assign dot = 39'(dt_r[0]) + 39'(dt_r[1]) + 39'(dt_r[2]);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ref_r[0] <= in_ref_x;
      ref_r[1] <= in_ref_y;
      ref_r[2] <= in_ref_z;
      tries_r  <= '0;
    end
    if (cmd.gen) begin
      u_r[0] <= u_r[1];
      u_r[1] <= u_r[2];
      u_r[2] <= u_r[3];
      u_r[3] <= {~w[31], w[30:16]};
    end
    if (cmd.sq) begin
      for (int i = 0; i < 4; i++) begin
        sq_r[i] <= 32'(u_r[i] * u_r[i]);
      end
      p_r[0] <= 34'(u_r[1] * u_r[3]);
      p_r[1] <= 34'(u_r[0] * u_r[2]);
      p_r[2] <= 34'(u_r[2] * u_r[3]);
      p_r[3] <= 34'(u_r[0] * u_r[1]);
    end
    if (cmd.sum) begin
      d2_r <= 33'(sq_r[0]) + 33'(sq_r[1]) + 33'(sq_r[2]) + 33'(sq_r[3]);
      if (tries_r != 8'd255) tries_r <= tries_r + 8'd1;
      p_r[4] <= 34'(sq_r[0]) + 34'(sq_r[3]);
      p_r[5] <= 34'(sq_r[1]) + 34'(sq_r[2]);
    end
    if (cmd.num) begin
      num_r[0] <= (p_r[0] + p_r[1]) <<< 1;
      num_r[1] <= (p_r[2] + p_r[3]) <<< 1;
      num_r[2] <= p_r[4] - p_r[5];
      comp_r   <= '0;
    end
    // A fresh component loads whenever the bit counter reads zero.
    if (cmd.num || cmd.div_next) begin
      if (cmd.div_next) begin
        dir_r[comp_r] <= neg_r ? -FieldW'({1'b0, qs}) : FieldW'({1'b0, qs});
        comp_r        <= comp_r + 2'd1;
      end
      bit_r <= 6'd0;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      if (bit_r == 6'd0) begin
        neg_r <= num_r[comp_r][33];
        dvd_r <= 50'({mag, 16'h0}) + 50'(d2_r >> 1);
        rem_r <= '0;
        bit_r <= 6'd1;
      end else begin
        if (rem_sub[34]) begin
          rem_r <= rem_sh[33:0];
          dvd_r <= {dvd_r[48:0], 1'b0};
        end else begin
          rem_r <= rem_sub[33:0];
          dvd_r <= {dvd_r[48:0], 1'b1};
        end
        bit_r <= bit_r + 6'd1;
      end
    end
    if (cmd.dot) begin
      for (int i = 0; i < 3; i++) begin
        dt_r[i] <= 37'(dir_r[i] * ref_r[i]);
      end
    end
    if (cmd.sumdot && !dot[38] && dot != 39'd0) begin
      for (int i = 0; i < 3; i++) dir_r[i] <= -dir_r[i];
    end
  end

  assign out_dir_x = dir_r[0];
  assign out_dir_y = dir_r[1];
  assign out_dir_z = dir_r[2];
  assign out_tries = tries_r;

endmodule

@@ hdl/random_hemisphere_direction_unit.sv @@
// ----------------------------------------------------------------------------
// random_hemisphere_direction_unit
// Random unit direction facing away from a reference vector.
// ----------------------------------------------------------------------------
// Each request on the in_ channel carries a Q1.16 reference vector. The unit
// draws four uniforms from two linear congruential generators, one generator
// step per cycle, and rejects the draw until its squared length is nonzero
// and at most one. The accepted quaternion is mapped to a direction, whose
// three components are divided by the squared length in a shared restoring
// divider, each in turn: a load, fifty quotient bits and a store. The dot
// product with the reference is then formed and tested, and the direction
// is negated when it points toward it. One request is in flight at a time,
// so in_stall is high from acceptance until the result is taken; the next
// request can be accepted in the cycle after that. The result waits on the
// out_ ports, held stable, for as long as out_stall is high. Reset returns
// the generators to their fixed seeds and the controller to idle.
// ----------------------------------------------------------------------------
module random_hemisphere_direction_unit
  import rhd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [FieldW-1:0] in_ref_x,
  input  logic signed [FieldW-1:0] in_ref_y,
  input  logic signed [FieldW-1:0] in_ref_z,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [FieldW-1:0] out_dir_x,
  output logic signed [FieldW-1:0] out_dir_y,
  output logic signed [FieldW-1:0] out_dir_z,
  output logic [TriesW-1:0]        out_tries
);

  rhd_cmd_t  cmd;
  rhd_stat_t stat;

  // Sequencer: owns the handshake and the order of work.
  rhd_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd, .stat
  );

  // Datapath: generators, arithmetic and result registers.
  rhd_dp u_dp (
    .clk, .rst_n, .cmd, .stat, .in_ref_x, .in_ref_y, .in_ref_z,
    .out_dir_x, .out_dir_y, .out_dir_z, .out_tries
  );

endmodule

@@ hdl/rhd_checker.sv @@
// ----------------------------------------------------------------------------
// rhd_checker
// Port-level checks of the random hemisphere direction unit.
// ----------------------------------------------------------------------------
module rhd_checker
  import rhd_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [FieldW-1:0] out_dir_x,
  input logic [TriesW-1:0]        out_tries
);

  // The unit never takes a request while a result is shown.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken with result pending");

  // A result never appears the cycle after a request.
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");

  // A result always used at least one draw.
  a_tries: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tries != 8'd0) else $error("zero tries");

  // A stalled result stays valid and its x component holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(out_dir_x))
    else $error("stalled result changed");

endmodule

bind random_hemisphere_direction_unit rhd_checker u_rhd_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall,
  .out_dir_x, .out_tries
);

@@ sim/random_hemisphere_direction_unit_tb.sv @@
// ----------------------------------------------------------------------------
// random_hemisphere_direction_unit_tb
// Self-checking bench for the random hemisphere direction unit.
// ----------------------------------------------------------------------------
// Reference vectors are queued by an initial block and offered by a clocked
// driver with random idle bursts. A clocked monitor takes results under random
// stall bursts and compares each against the oldest prediction, which a
// generator-accurate copy of the unit computes when the request is accepted.
// ----------------------------------------------------------------------------
module random_hemisphere_direction_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rhd_pkg::*;

  typedef struct {
    logic signed [FieldW-1:0] x;
    logic signed [FieldW-1:0] y;
    logic signed [FieldW-1:0] z;
  } ref_vec_t;

  typedef struct {
    logic signed [FieldW-1:0] x;
    logic signed [FieldW-1:0] y;
    logic signed [FieldW-1:0] z;
    logic [TriesW-1:0]        tries;
  } direction_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [FieldW-1:0] in_ref_x;
  logic signed [FieldW-1:0] in_ref_y;
  logic signed [FieldW-1:0] in_ref_z;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [FieldW-1:0] out_dir_x;
  logic signed [FieldW-1:0] out_dir_y;
  logic signed [FieldW-1:0] out_dir_z;
  logic [TriesW-1:0]        out_tries;

  ref_vec_t   pending_refs[$];
  direction_t expected_dirs[$];

  // Private copy of the two generators, advanced only on accepted requests.
  logic [31:0] lcg_one;
  logic [31:0] lcg_two;

  int  error_count = 0;
  bit  quiet_phase;
  bit  hold_off;
  int  send_gap;
  int  take_gap;
  int  hold_cycles;

  random_hemisphere_direction_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_ref_x  (in_ref_x),
    .in_ref_y  (in_ref_y),
    .in_ref_z  (in_ref_z),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_dir_x (out_dir_x),
    .out_dir_y (out_dir_y),
    .out_dir_z (out_dir_z),
    .out_tries (out_tries)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Steps both generators and returns one uniform in Q1.15, in [-32768, 32767].
  function automatic longint draw_uniform();
    logic [31:0] word;
    lcg_one = lcg_one * MulOne + AddOne;
    lcg_two = lcg_two * MulTwo + AddTwo;
    word = (lcg_one << 16) ^ lcg_two;
    return longint'(word[31:16]) - 32768;
  endfunction

  // Scales a Q2.30 numerator to Q1.16 by dividing by d2, rounding half away
  // from zero and clamping the magnitude to one.
  function automatic longint unit_quotient(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag * 65536 + den / 2) / den;
    if (q > 65536) q = 65536;
    return (num < 0) ? -q : q;
  endfunction

  // Draws a quaternion until it lies inside the unit ball, maps it to a
  // direction and turns it away from the reference.
  function automatic direction_t hemisphere_direction(ref_vec_t r);
    direction_t d;
    longint a0, a1, a2, a3, d2, dx, dy, dz, dot;
    int tries;
    tries = 0;
    forever begin
      a0 = draw_uniform();
      a1 = draw_uniform();
      a2 = draw_uniform();
      a3 = draw_uniform();
      if (tries < 255) tries++;
      d2 = a0 * a0 + a1 * a1 + a2 * a2 + a3 * a3;
      if (d2 != 0 && d2 <= (64'sd1 << 30)) break;
    end
    dx = unit_quotient(2 * (a1 * a3 + a0 * a2), d2);
    dy = unit_quotient(2 * (a2 * a3 + a0 * a1), d2);
    dz = unit_quotient(a0 * a0 + a3 * a3 - a1 * a1 - a2 * a2, d2);
    dot = dx * longint'(r.x) + dy * longint'(r.y) + dz * longint'(r.z);
    if (dot > 0) begin
      dx = -dx;
      dy = -dy;
      dz = -dz;
    end
    d.x = dx[FieldW-1:0];
    d.y = dy[FieldW-1:0];
    d.z = dz[FieldW-1:0];
    d.tries = tries[TriesW-1:0];
    return d;
  endfunction

  function automatic ref_vec_t make_ref(int x, int y, int z);
    ref_vec_t r;
    r.x = x[FieldW-1:0];
    r.y = y[FieldW-1:0];
    r.z = z[FieldW-1:0];
    return r;
  endfunction

  // Random component: mostly inside the Q1.16 unit range, sometimes any
  // 18-bit pattern so every bit and the out-of-range codes are reached.
  function automatic int random_component();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(0, 262143));
    if ($urandom_range(0, 9) == 0) return 0;
    return int'($urandom_range(0, 131072)) - 65536;
  endfunction

  initial begin
    int i;
    // Directed requests: zero reference, unit axes, the range ends and the
    // raw 18-bit extremes outside the stated range.
    pending_refs.push_back(make_ref(0, 0, 0));
    pending_refs.push_back(make_ref(65536, 0, 0));
    pending_refs.push_back(make_ref(-65536, 0, 0));
    pending_refs.push_back(make_ref(0, 65536, 0));
    pending_refs.push_back(make_ref(0, -65536, 0));
    pending_refs.push_back(make_ref(0, 0, 65536));
    pending_refs.push_back(make_ref(0, 0, -65536));
    pending_refs.push_back(make_ref(65536, 65536, 65536));
    pending_refs.push_back(make_ref(-65536, -65536, -65536));
    pending_refs.push_back(make_ref(131071, 131071, 131071));
    pending_refs.push_back(make_ref(-131072, -131072, -131072));
    pending_refs.push_back(make_ref(131071, -131072, 1));
    pending_refs.push_back(make_ref(-1, -1, -1));
    pending_refs.push_back(make_ref(1, 0, 0));
    pending_refs.push_back(make_ref(0, 0, 0));
    for (i = 0; i < 2000; i++) begin
      pending_refs.push_back(make_ref(random_component(), random_component(),
                                      random_component()));
    end
  end

  // Reset is asserted once, at the start of the run.
  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver. The request stays on the ports until accepted; between requests
  // the sender may pause for a random burst. No new pause starts in the quiet phase.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_ref_x <= '0;
      in_ref_y <= '0;
      in_ref_z <= '0;
      send_gap <= 0;
      lcg_one  <= GenOneReset;
      lcg_two  <= GenTwoReset;
    end else begin
      if (in_valid && !in_stall) begin
        // The prediction is made right at acceptance so the generator copy
        // advances in step with the unit.
        expected_dirs.push_back(hemisphere_direction(pending_refs.pop_front()));
      end
      if (in_valid && in_stall) begin
        // Hold the stalled request unchanged.
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_refs.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(1, 18) - 1;
      end else begin
        // Offer the next queued request; an accepted head was popped above.
        in_valid <= 1'b1;
        in_ref_x <= pending_refs[0].x;
        in_ref_y <= pending_refs[0].y;
        in_ref_z <= pending_refs[0].z;
      end
    end
  end

  // The quiet phase covers roughly the last tenth of the requests.
  always @(posedge clk) begin
    quiet_phase <= (pending_refs.size() < 200);
  end

  // One long receiver hold-off early in the run so the unit fills and backs
  // up its input while the sender keeps offering.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off    <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_cycles < 2000) begin
      hold_cycles <= hold_cycles + 1;
      hold_off    <= (hold_cycles >= 300 && hold_cycles < 1800);
    end else begin
      hold_off <= 1'b0;
    end
  end

  // Monitor. Each taken result is checked field by field against the oldest
  // prediction; the stall line follows random bursts outside the quiet phase.
  always @(posedge clk) begin
    direction_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      take_gap  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_dirs.size() == 0) begin
          $error("result with no request outstanding: x=%0d y=%0d z=%0d tries=%0d",
                 out_dir_x, out_dir_y, out_dir_z, out_tries);
          error_count++;
        end else begin
          want = expected_dirs.pop_front();
          if (out_dir_x !== want.x) begin
            $error("dir_x expected %0d actual %0d", want.x, out_dir_x);
            error_count++;
          end
          if (out_dir_y !== want.y) begin
            $error("dir_y expected %0d actual %0d", want.y, out_dir_y);
            error_count++;
          end
          if (out_dir_z !== want.z) begin
            $error("dir_z expected %0d actual %0d", want.z, out_dir_z);
            error_count++;
          end
          if (out_tries !== want.tries) begin
            $error("tries expected %0d actual %0d", want.tries, out_tries);
            error_count++;
          end
        end
      end
      if (hold_off) begin
        out_stall <= 1'b1;
      end else if (take_gap > 0) begin
        out_stall <= 1'b1;
        take_gap  <= take_gap - 1;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        take_gap  <= $urandom_range(1, 18) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // End of run: every request accepted, every result taken, then a short
  // drain to catch any spurious extra result.
  initial begin
    @(posedge rst_n);
    while (pending_refs.size() != 0 || expected_dirs.size() != 0) begin
      @(posedge clk);
    end
    repeat (400) @(posedge clk);
    if (error_count == 0 && expected_dirs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Worst case is roughly 2000 requests plus stalls; this bound is many times that.
  initial begin
    #50ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
